// ----- hw/rtl/cholesky_linear_solve_assert.svh -----
// assertion macros for the cholesky linear solver
// included by the rtl files that carry concurrent checks
`ifndef CHOLESKY_LINEAR_SOLVE_ASSERT_SVH
`define CHOLESKY_LINEAR_SOLVE_ASSERT_SVH
`ifndef SYNTHESIS
`define CHOL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cholesky solver check failed");
`define CHOL_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cholesky solver check failed");
`else
`define CHOL_ASSERT(lbl, clk, rst_n, prop)
`define CHOL_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ----- hw/rtl/chol_pkg.sv -----
// shared types, constants and helpers of the cholesky linear solver
// no dependencies
package chol_pkg;

  localparam int MAX_ORDER = 16;
  localparam int IDX_W     = $clog2(MAX_ORDER);
  localparam int CNT_W     = $clog2(MAX_ORDER + 1);
  localparam int ADR_W     = 2 * IDX_W;
  localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
  localparam int DIV_STEPS = 48;
  localparam int SQRT_STEPS = 24;

  typedef enum logic [1:0] {
    ACT_MAT   = 2'd0,
    ACT_RHS   = 2'd1,
    ACT_SOLVE = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [4:0] {
    ST_IDLE, F_INIT, F_LOAD, F_RD, F_MUL, F_ACC, F_END, F_PIV, F_SQW, F_DVW,
    S_INIT, S_LOAD, S_RD, S_MUL, S_ACC, S_END, S_DIV, S_DVW,
    O_RD, O_LD, O_WAIT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_st_t;

  // acc - floor(prod / 2^16), saturated to 32 bits
  function automatic logic signed [31:0] sub_mul_sat(logic signed [31:0] acc,
                                                     logic signed [63:0] prod);
    logic signed [63:0] sh;
    logic signed [49:0] d;
    sh = prod >>> 16;
    d  = 50'(acc) - sh[49:0];
    if (d > 50'sd2147483647)       sub_mul_sat = 32'sh7fffffff;
    else if (d < -50'sd2147483648) sub_mul_sat = 32'sh80000000;
    else                           sub_mul_sat = d[31:0];
  endfunction

endpackage

// ----- hw/rtl/chol_div.sv -----
// bit-serial q16.16 divider, (num * 2^16) / den toward zero, saturated
// depends on chol_pkg; den is positive
module chol_div import chol_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output unit_st_t           st_o,
  output logic signed [31:0] quot_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic [31:0] den_q, den_d, rem_q, rem_d, mag;
  logic [47:0] quo_q, quo_d;
  logic [31:0] rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    mag    = num_i[31] ? 32'(-num_i) : 32'(num_i);
    rem_sh = {rem_q[30:0], quo_q[47]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = num_i[31];
      den_d  = 32'(den_i);
      rem_d  = '0;
      quo_d  = {mag, 16'd0};
    end else if (busy_q) begin
      if (rem_sh >= den_q) begin
        rem_d = rem_sh - den_q;
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  always_comb begin
    if (neg_q) begin
      if (quo_q > 48'h0000_8000_0000) quot_o = 32'sh80000000;
      else                            quot_o = -$signed(quo_q[31:0]);
    end else begin
      if (quo_q > 48'h0000_7fff_ffff) quot_o = 32'sh7fffffff;
      else                            quot_o = $signed(quo_q[31:0]);
    end
  end

  assign st_o = '{busy: busy_q, done: done_q};

endmodule

// ----- hw/rtl/chol_sqrt.sv -----
// digit-by-digit square root, floor(sqrt(s * 2^16)) for positive s
// depends on chol_pkg
module chol_sqrt import chol_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] rad_i,
  output unit_st_t           st_o,
  output logic signed [31:0] root_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [47:0] x_q, x_d;
  logic [24:0] rem_q, rem_d;
  logic [23:0] root_q, root_d;
  logic [26:0] rem_sh, trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    rem_sh = {rem_q, x_q[47:46]};
    trial  = {1'b0, root_q, 2'b01};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      x_d    = {rad_i, 16'd0};
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      x_d = {x_q[45:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = 25'(rem_sh - trial);
        root_d = {root_q[22:0], 1'b1};
      end else begin
        rem_d  = rem_sh[24:0];
        root_d = {root_q[22:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(SQRT_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = $signed({8'd0, root_q});
  assign st_o   = '{busy: busy_q, done: done_q};

endmodule

// ----- hw/rtl/cholesky_linear_solve.sv -----
// cholesky linear solver top: stores, sequencer, shared multiply-accumulate
// depends on chol_pkg, chol_div, chol_sqrt and cholesky_linear_solve_assert.svh
//
// Load beats (matrix entry, right-hand-side entry) are accepted whenever the
// solver is idle. A solve beat holds the input stalled while one shared 32x32
// multiplier walks the lower triangle: each multiply-subtract step reads its
// operands, multiplies and then subtracts; each off-diagonal factor and each
// substitution divide runs in the bit-serial divider, each diagonal root in
// the serial square root. After the solve the n results leave in index order,
// each held until it is taken. A pivot sum of zero or less ends factoring
// early and gives n beats of zero with error set. Stores are not initialized:
// entries must be written first.
module cholesky_linear_solve import chol_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         in_action_i,
  input  logic [3:0]         in_row_i,
  input  logic [3:0]         in_col_i,
  input  logic signed [31:0] in_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         out_index_o,
  output logic signed [31:0] out_solution_o,
  output logic               out_last_o,
  output logic               out_error_o
);

  `include "cholesky_linear_solve_assert.svh"

  state_e state_q, state_d;
  logic [4:0]  size_q;
  logic [CNT_W-1:0] n_q, n_d, i_q, i_d, j_q, j_d, k_q, k_d, n_clamp;
  logic        bwd_q, bwd_d, fault_q, fault_d;
  logic signed [31:0] s_q, s_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [31:0] mul_b;

  // memories
  logic signed [31:0] mat_mem [DEPTH];
  logic signed [31:0] l_mem   [DEPTH];
  logic signed [31:0] rhs_mem [MAX_ORDER];
  logic signed [31:0] x_mem   [MAX_ORDER];
  logic signed [31:0] mat_rd_q, la_rd_q, lb_rd_q, rhs_rd_q, x_rd_q;
  logic [ADR_W-1:0] mat_ra, la_ra, lb_ra, l_wa;
  logic [IDX_W-1:0] rhs_ra, x_ra, x_wa;
  logic signed [31:0] l_wd, x_wd;
  logic l_we, x_we;

  // output register
  logic        ov_q, ov_d, olast_q, olast_d, oerr_q, oerr_d;
  logic [IDX_W-1:0] oidx_q, oidx_d;
  logic signed [31:0] osol_q, osol_d;

  // arithmetic units
  logic div_start, sqrt_start;
  logic signed [31:0] div_num, div_den, div_q, sqrt_r;
  unit_st_t div_st, sqrt_st;

  logic accept, ld_mat, ld_rhs;
  logic [CNT_W-1:0] k_inc;

  assign accept = in_valid_i && !in_stall_o;
  assign ld_mat = accept && in_action_i == ACT_MAT &&
                  int'(in_row_i) < MAX_ORDER && int'(in_col_i) < MAX_ORDER;
  assign ld_rhs = accept && in_action_i == ACT_RHS && int'(in_row_i) < MAX_ORDER;

  always_comb begin
    if (size_q == 5'd0)                 n_clamp = CNT_W'(1);
    else if (int'(size_q) > MAX_ORDER)  n_clamp = CNT_W'(MAX_ORDER);
    else                                n_clamp = CNT_W'(size_q);
  end

  chol_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .st_o(div_st), .quot_o(div_q)
  );

  chol_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .rad_i(s_q),
    .st_o(sqrt_st), .root_o(sqrt_r)
  );

  assign div_num = s_q;
  assign div_den = la_rd_q;
  assign k_inc   = k_q + CNT_W'(1);
  assign mul_b   = (state_q == S_MUL) ? x_rd_q : lb_rd_q;

  always_comb begin
    state_d = state_q;
    n_d = n_q; i_d = i_q; j_d = j_q; k_d = k_q;
    bwd_d = bwd_q; fault_d = fault_q;
    s_d = s_q;
    prod_d = prod_q;
    mat_ra = {i_q[IDX_W-1:0], j_q[IDX_W-1:0]};
    la_ra  = {i_q[IDX_W-1:0], k_q[IDX_W-1:0]};
    lb_ra  = {j_q[IDX_W-1:0], k_q[IDX_W-1:0]};
    rhs_ra = i_q[IDX_W-1:0];
    x_ra   = i_q[IDX_W-1:0];
    l_we = 1'b0; l_wa = {i_q[IDX_W-1:0], j_q[IDX_W-1:0]}; l_wd = sqrt_r;
    x_we = 1'b0; x_wa = i_q[IDX_W-1:0]; x_wd = div_q;
    div_start = 1'b0; sqrt_start = 1'b0;
    ov_d = ov_q; olast_d = olast_q; oerr_d = oerr_q; oidx_d = oidx_q; osol_d = osol_q;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_action_i == ACT_SOLVE) begin
          n_d = n_clamp; i_d = '0; j_d = '0; fault_d = 1'b0;
          state_d = F_INIT;
        end
      end
      F_INIT: state_d = F_LOAD;
      F_LOAD: begin
        s_d = mat_rd_q;
        k_d = '0;
        state_d = (j_q == '0) ? F_END : F_RD;
      end
      F_RD:  state_d = F_MUL;
      F_MUL: begin
        prod_d = la_rd_q * mul_b;
        state_d = F_ACC;
      end
      F_ACC: begin
        s_d = sub_mul_sat(s_q, prod_q);
        k_d = k_inc;
        state_d = (k_inc < j_q) ? F_RD : F_END;
      end
      F_END: begin
        la_ra = {j_q[IDX_W-1:0], j_q[IDX_W-1:0]};
        if (i_q == j_q) begin
          if (s_q <= 0) begin
            fault_d = 1'b1;
            oidx_d  = '0;
            state_d = O_RD;
          end else begin
            sqrt_start = 1'b1;
            state_d = F_SQW;
          end
        end else begin
          state_d = F_PIV;
        end
      end
      F_PIV: begin
        div_start = 1'b1;
        state_d = F_DVW;
      end
      F_SQW: begin
        if (sqrt_st.done) begin
          l_we = 1'b1;
          if (i_q + CNT_W'(1) == n_q) begin
            i_d = '0; bwd_d = 1'b0;
            state_d = S_INIT;
          end else begin
            i_d = i_q + CNT_W'(1); j_d = '0;
            state_d = F_INIT;
          end
        end
      end
      F_DVW: begin
        if (div_st.done) begin
          l_we = 1'b1; l_wd = div_q;
          j_d = j_q + CNT_W'(1);
          state_d = F_INIT;
        end
      end
      S_INIT: state_d = S_LOAD;
      S_LOAD: begin
        if (bwd_q) begin
          s_d = x_rd_q;
          k_d = i_q + CNT_W'(1);
          state_d = (i_q + CNT_W'(1) < n_q) ? S_RD : S_END;
        end else begin
          s_d = rhs_rd_q;
          k_d = '0;
          state_d = (i_q != '0) ? S_RD : S_END;
        end
      end
      S_RD: begin
        la_ra = bwd_q ? {k_q[IDX_W-1:0], i_q[IDX_W-1:0]} : {i_q[IDX_W-1:0], k_q[IDX_W-1:0]};
        x_ra  = k_q[IDX_W-1:0];
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d = la_rd_q * mul_b;
        state_d = S_ACC;
      end
      S_ACC: begin
        s_d = sub_mul_sat(s_q, prod_q);
        k_d = k_inc;
        if (bwd_q) state_d = (k_inc < n_q) ? S_RD : S_END;
        else       state_d = (k_inc < i_q) ? S_RD : S_END;
      end
      S_END: begin
        la_ra = {i_q[IDX_W-1:0], i_q[IDX_W-1:0]};
        state_d = S_DIV;
      end
      S_DIV: begin
        div_start = 1'b1;
        state_d = S_DVW;
      end
      S_DVW: begin
        if (div_st.done) begin
          x_we = 1'b1;
          if (!bwd_q) begin
            if (i_q + CNT_W'(1) == n_q) begin
              bwd_d = 1'b1; i_d = n_q - CNT_W'(1);
            end else begin
              i_d = i_q + CNT_W'(1);
            end
            state_d = S_INIT;
          end else if (i_q == '0) begin
            oidx_d = '0;
            state_d = O_RD;
          end else begin
            i_d = i_q - CNT_W'(1);
            state_d = S_INIT;
          end
        end
      end
      O_RD: begin
        x_ra = oidx_q;
        state_d = O_LD;
      end
      O_LD: begin
        ov_d    = 1'b1;
        osol_d  = fault_q ? 32'sd0 : x_rd_q;
        olast_d = (CNT_W'(oidx_q) + CNT_W'(1) == n_q);
        oerr_d  = fault_q;
        state_d = O_WAIT;
      end
      O_WAIT: begin
        if (!out_stall_i) begin
          ov_d = 1'b0;
          if (olast_q) begin
            state_d = ST_IDLE;
          end else begin
            oidx_d = oidx_q + IDX_W'(1);
            state_d = O_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      size_q  <= 5'd16;
      fault_q <= 1'b0;
      ov_q    <= 1'b0;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      bwd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) size_q <= cfg_wdata_i;
      fault_q <= fault_d;
      ov_q    <= ov_d;
      n_q     <= n_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      bwd_q   <= bwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q     <= s_d;
    prod_q  <= prod_d;
    oidx_q  <= oidx_d;
    osol_q  <= osol_d;
    olast_q <= olast_d;
    oerr_q  <= oerr_d;
  end

  // stores, registered reads
  always_ff @(posedge clk_i) begin
    if (ld_mat) mat_mem[{in_row_i[IDX_W-1:0], in_col_i[IDX_W-1:0]}] <= in_value_i;
    mat_rd_q <= mat_mem[mat_ra];
  end

  always_ff @(posedge clk_i) begin
    if (l_we) l_mem[l_wa] <= l_wd;
    la_rd_q <= l_mem[la_ra];
    lb_rd_q <= l_mem[lb_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ld_rhs) rhs_mem[in_row_i[IDX_W-1:0]] <= in_value_i;
    rhs_rd_q <= rhs_mem[rhs_ra];
  end

  always_ff @(posedge clk_i) begin
    if (x_we) x_mem[x_wa] <= x_wd;
    x_rd_q <= x_mem[x_ra];
  end

  assign out_valid_o    = ov_q;
  assign out_index_o    = oidx_q;
  assign out_solution_o = osol_q;
  assign out_last_o     = olast_q;
  assign out_error_o    = oerr_q;

  `CHOL_ASSERT(a_busy_while_out, clk_i, rst_ni, !out_valid_o || in_stall_o)
  `CHOL_ASSERT(a_err_zero, clk_i, rst_ni, !(out_valid_o && out_error_o) || out_solution_o == 32'sd0)
  `CHOL_ASSERT_NEXT(a_last_ends, clk_i, rst_ni, out_valid_o && out_last_o && !out_stall_i, !out_valid_o && !in_stall_o)

endmodule
